@@ src/kmp_pkg.sv @@
// Shared types, microcode encodings and register indexes for the KMP substring search block.
`default_nettype none

package kmp_pkg;

   localparam int TEXT_BITS     = 8;
   localparam int MATCH_BITS    = 16;
   localparam int PAT_REG_BITS  = 64;
   localparam int PAT_LEN_BITS  = 5;
   localparam int PAT_BYTES     = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int UPC_BITS      = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PAT_LO  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAT_HI  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAT_LEN = 2'd2;

   typedef struct packed {
      logic [TEXT_BITS-1:0] text_byte;
      logic                 first_of_text;
      logic                 last_of_text;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [MATCH_BITS-1:0] match_position;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_NOP,
      OP_BINIT,
      OP_BREAD,
      OP_BFALL,
      OP_BSTORE,
      OP_BFIN,
      OP_PREP,
      OP_SREAD,
      OP_SFALL,
      OP_SADV,
      OP_SRES,
      OP_END
   } op_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NO_BEAT,
      C_TBL_READY,
      C_I_DONE,
      C_BHIT,
      C_DONE,
      C_SHIT,
      C_RSP_BLOCK
   } cond_sel_type;

   typedef struct packed {
      op_type               op;
      cond_sel_type         cond;
      logic [UPC_BITS-1:0]  target;
   } ucode_word_type;

   typedef struct packed {
      logic beat;
      logic tbl_ready;
      logic i_done;
      logic bhit;
      logic done;
      logic shit;
      logic rsp_block;
   } flags_type;

   localparam logic [UPC_BITS-1:0] U_IDLE   = 4'd0;
   localparam logic [UPC_BITS-1:0] U_CHKTBL = 4'd1;
   localparam logic [UPC_BITS-1:0] U_BINIT  = 4'd2;
   localparam logic [UPC_BITS-1:0] U_BLOOP  = 4'd3;
   localparam logic [UPC_BITS-1:0] U_BCMP   = 4'd4;
   localparam logic [UPC_BITS-1:0] U_BFALL  = 4'd5;
   localparam logic [UPC_BITS-1:0] U_BSTORE = 4'd6;
   localparam logic [UPC_BITS-1:0] U_BFIN   = 4'd7;
   localparam logic [UPC_BITS-1:0] U_PREP   = 4'd8;
   localparam logic [UPC_BITS-1:0] U_SCHK   = 4'd9;
   localparam logic [UPC_BITS-1:0] U_SCMP   = 4'd10;
   localparam logic [UPC_BITS-1:0] U_SFALL  = 4'd11;
   localparam logic [UPC_BITS-1:0] U_SADV   = 4'd12;
   localparam logic [UPC_BITS-1:0] U_SRES   = 4'd13;
   localparam logic [UPC_BITS-1:0] U_END    = 4'd14;

endpackage

`default_nettype wire

@@ src/kmp_sequencer.sv @@
// Microcode sequencer: program table, step counter and conditional jump logic.
`default_nettype none

module kmp_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire kmp_pkg::flags_type  flags,
   output kmp_pkg::op_type          op
);

   function automatic kmp_pkg::ucode_word_type rom(input logic [kmp_pkg::UPC_BITS-1:0] a);
      kmp_pkg::ucode_word_type w;
      case (a)
         kmp_pkg::U_IDLE:   w = '{kmp_pkg::OP_WAIT,   kmp_pkg::C_NO_BEAT,   kmp_pkg::U_IDLE};
         kmp_pkg::U_CHKTBL: w = '{kmp_pkg::OP_NOP,    kmp_pkg::C_TBL_READY, kmp_pkg::U_PREP};
         kmp_pkg::U_BINIT:  w = '{kmp_pkg::OP_BINIT,  kmp_pkg::C_ALWAYS,    kmp_pkg::U_BLOOP};
         kmp_pkg::U_BLOOP:  w = '{kmp_pkg::OP_NOP,    kmp_pkg::C_I_DONE,    kmp_pkg::U_BFIN};
         kmp_pkg::U_BCMP:   w = '{kmp_pkg::OP_BREAD,  kmp_pkg::C_BHIT,      kmp_pkg::U_BSTORE};
         kmp_pkg::U_BFALL:  w = '{kmp_pkg::OP_BFALL,  kmp_pkg::C_ALWAYS,    kmp_pkg::U_BCMP};
         kmp_pkg::U_BSTORE: w = '{kmp_pkg::OP_BSTORE, kmp_pkg::C_ALWAYS,    kmp_pkg::U_BLOOP};
         kmp_pkg::U_BFIN:   w = '{kmp_pkg::OP_BFIN,   kmp_pkg::C_ALWAYS,    kmp_pkg::U_PREP};
         kmp_pkg::U_PREP:   w = '{kmp_pkg::OP_PREP,   kmp_pkg::C_ALWAYS,    kmp_pkg::U_SCHK};
         kmp_pkg::U_SCHK:   w = '{kmp_pkg::OP_NOP,    kmp_pkg::C_DONE,      kmp_pkg::U_END};
         kmp_pkg::U_SCMP:   w = '{kmp_pkg::OP_SREAD,  kmp_pkg::C_SHIT,      kmp_pkg::U_SADV};
         kmp_pkg::U_SFALL:  w = '{kmp_pkg::OP_SFALL,  kmp_pkg::C_ALWAYS,    kmp_pkg::U_SCMP};
         kmp_pkg::U_SADV:   w = '{kmp_pkg::OP_SADV,   kmp_pkg::C_ALWAYS,    kmp_pkg::U_SRES};
         kmp_pkg::U_SRES:   w = '{kmp_pkg::OP_SRES,   kmp_pkg::C_RSP_BLOCK, kmp_pkg::U_SRES};
         kmp_pkg::U_END:    w = '{kmp_pkg::OP_END,    kmp_pkg::C_ALWAYS,    kmp_pkg::U_IDLE};
         default:           w = '{kmp_pkg::OP_NOP,    kmp_pkg::C_ALWAYS,    kmp_pkg::U_IDLE};
      endcase
      return w;
   endfunction

   logic [kmp_pkg::UPC_BITS-1:0] upc_ff;
   logic [kmp_pkg::UPC_BITS-1:0] upc_in;
   kmp_pkg::ucode_word_type      word;
   logic                         taken;

   always_comb begin
      word = rom(upc_ff);
      case (word.cond)
         kmp_pkg::C_ALWAYS:    taken = 1'b1;
         kmp_pkg::C_NO_BEAT:   taken = !flags.beat;
         kmp_pkg::C_TBL_READY: taken = flags.tbl_ready;
         kmp_pkg::C_I_DONE:    taken = flags.i_done;
         kmp_pkg::C_BHIT:      taken = flags.bhit;
         kmp_pkg::C_DONE:      taken = flags.done;
         kmp_pkg::C_SHIT:      taken = flags.shit;
         kmp_pkg::C_RSP_BLOCK: taken = flags.rsp_block;
         default:              taken = 1'b1;
      endcase
      upc_in = taken ? word.target : upc_ff + 4'd1;
      op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= kmp_pkg::U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

@@ src/kmp_datapath.sv @@
// Datapath of the KMP search: pattern registers, failure table memory, matcher and result register.
`default_nettype none

module kmp_datapath #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire kmp_pkg::op_type                     op,
   output kmp_pkg::flags_type                       flags,
   input  wire logic                                csr_we,
   input  wire logic [kmp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [kmp_pkg::PAT_REG_BITS-1:0]    csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire kmp_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output kmp_pkg::rsp_type                         rsp_payload
);

   localparam int LB = kmp_pkg::PAT_LEN_BITS;
   localparam int TW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int AW = (TW > LB) ? TW : LB;
   localparam int PB = POSITION_BITS;
   localparam int RW = (PB > kmp_pkg::MATCH_BITS) ? PB : kmp_pkg::MATCH_BITS;

   function automatic logic [7:0] pat_byte(input logic [2*kmp_pkg::PAT_REG_BITS-1:0] pat,
                                           input logic [LB-1:0] k);
      logic [7:0] b;
      b = 8'd0;
      if (!k[LB-1]) begin
         b = pat[{k[LB-2:0], 3'b000} +: 8];
      end
      return b;
   endfunction

   logic [kmp_pkg::PAT_REG_BITS-1:0] pat_lo_ff;
   logic [kmp_pkg::PAT_REG_BITS-1:0] pat_hi_ff;
   logic [LB-1:0]                    plen_ff;
   logic                             ready_ff;
   logic [LB-1:0]                    k_ff, k_in;
   logic [LB-1:0]                    i_ff, i_in;
   logic [LB-1:0]                    pidx_ff, pidx_in;
   logic [PB-1:0]                    pos_ff, pos_in;
   logic                             done_ff, done_in;
   kmp_pkg::req_type                 item_ff;
   logic [LB-1:0]                    rd_ff;
   logic [LB-1:0]                    mem [MAX_PATTERN];
   logic                             rsp_valid_ff, rsp_valid_in;
   kmp_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [2*kmp_pkg::PAT_REG_BITS-1:0] pat;
   logic [LB-1:0]                    n1;
   logic [LB-1:0]                    len;
   logic                             bmatch;
   logic                             smatch;
   logic [LB-1:0]                    knew;
   logic [AW-1:0]                    rd_wide;
   logic [AW-1:0]                    wr_wide;
   logic [TW-1:0]                    rd_addr;
   logic [TW-1:0]                    wr_addr;
   logic                             wr_en;
   logic                             found;
   logic                             need_rsp;
   logic                             busy;
   logic [LB-1:0]                    pidx0;
   logic [PB-1:0]                    pos0;
   logic [PB-1:0]                    start;
   logic [RW-1:0]                    start_wide;

   always_comb begin
      pat = {pat_hi_ff, pat_lo_ff};
      n1 = (plen_ff == '0) ? LB'(1) : plen_ff;
      len = (32'(n1) > MAX_PATTERN) ? LB'(MAX_PATTERN) : n1;
      bmatch = pat_byte(pat, i_ff) == pat_byte(pat, k_ff);
      smatch = pat_byte(pat, pidx_ff) == item_ff.text_byte;
      knew = k_ff + LB'(bmatch);
      found = pidx_ff >= len;
      need_rsp = found || item_ff.last_of_text;
      busy = rsp_valid_ff && !rsp_ready;

      if (op == kmp_pkg::OP_BREAD) begin
         rd_wide = AW'(k_ff - LB'(1));
      end else begin
         rd_wide = AW'(pidx_ff - LB'(1));
      end
      rd_addr = rd_wide[TW-1:0];
      wr_wide = (op == kmp_pkg::OP_BINIT) ? '0 : AW'(i_ff);
      wr_addr = wr_wide[TW-1:0];
      wr_en = (op == kmp_pkg::OP_BINIT) || (op == kmp_pkg::OP_BSTORE);

      pidx0 = item_ff.first_of_text ? '0 : pidx_ff;
      pos0 = item_ff.first_of_text ? '0 : pos_ff;
      if (PB'(len) <= pos_ff) begin
         start = pos_ff - PB'(len) + PB'(1);
      end else begin
         start = PB'(1);
      end
      start_wide = RW'(start);

      k_in = k_ff;
      i_in = i_ff;
      pidx_in = pidx_ff;
      pos_in = pos_ff;
      done_in = done_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (op)
         kmp_pkg::OP_BINIT: begin
            k_in = '0;
            i_in = LB'(1);
         end
         kmp_pkg::OP_BFALL: begin
            k_in = rd_ff;
         end
         kmp_pkg::OP_BSTORE: begin
            k_in = knew;
            i_in = i_ff + LB'(1);
         end
         kmp_pkg::OP_BFIN: begin
            pidx_in = '0;
         end
         kmp_pkg::OP_PREP: begin
            pidx_in = (pidx0 >= len) ? '0 : pidx0;
            pos_in = (pos0 == '1) ? pos0 : pos0 + PB'(1);
            done_in = item_ff.first_of_text ? 1'b0 : done_ff;
         end
         kmp_pkg::OP_SFALL: begin
            pidx_in = rd_ff;
         end
         kmp_pkg::OP_SADV: begin
            pidx_in = pidx_ff + LB'(smatch);
         end
         kmp_pkg::OP_SRES: begin
            if (need_rsp && !busy) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = found;
               rsp_in.match_position = found ? start_wide[kmp_pkg::MATCH_BITS-1:0] : '0;
               if (found) begin
                  done_in = 1'b1;
                  pidx_in = '0;
               end
            end
         end
         kmp_pkg::OP_END: begin
            if (item_ff.last_of_text) begin
               pidx_in = '0;
               pos_in = '0;
               done_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      flags.beat = req_valid;
      flags.tbl_ready = ready_ff;
      flags.i_done = i_ff >= len;
      flags.bhit = (k_ff == '0) || bmatch;
      flags.done = done_ff;
      flags.shit = (pidx_ff == '0) || smatch;
      flags.rsp_block = need_rsp && busy;

      req_ready = op == kmp_pkg::OP_WAIT;
      rsp_valid = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (op == kmp_pkg::OP_BINIT) ? '0 : knew;
      end
      if (op == kmp_pkg::OP_BREAD || op == kmp_pkg::OP_SREAD) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         plen_ff <= LB'(1);
         ready_ff <= 1'b0;
         pidx_ff <= '0;
         pos_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pidx_ff <= pidx_in;
         pos_ff <= pos_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (op == kmp_pkg::OP_BFIN) begin
            ready_ff <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               kmp_pkg::CSR_PAT_LO: begin
                  pat_lo_ff <= csr_wdata;
                  ready_ff <= 1'b0;
               end
               kmp_pkg::CSR_PAT_HI: begin
                  pat_hi_ff <= csr_wdata;
                  ready_ff <= 1'b0;
               end
               kmp_pkg::CSR_PAT_LEN: begin
                  plen_ff <= csr_wdata[LB-1:0];
                  ready_ff <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      i_ff <= i_in;
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

endmodule

`default_nettype wire

@@ src/kmp_substring_search.sv @@
// Top level of the KMP substring search: microcode sequencer driving the matcher datapath.
// A text byte is taken in the wait step and then passes through the matcher, plus a fallback
// step for each matcher fallback; bytes after a match in the same text skip the matcher.
// The first byte after a pattern write also builds the table, with a fallback step for each
// builder fallback; a new byte is taken only back in the wait step; a result waits in its register.
// Reset is synchronous; it clears the pattern registers, the matcher state and the table flag.
`default_nettype none

module kmp_substring_search #(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [kmp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [kmp_pkg::PAT_REG_BITS-1:0] csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire kmp_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output kmp_pkg::rsp_type                      rsp_payload
);

   kmp_pkg::op_type    op;
   kmp_pkg::flags_type flags;

   kmp_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   kmp_datapath #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .flags       (flags),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_beat_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer stayed in the wait step after an input beat");

   a_rsp_from_result_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(op) == kmp_pkg::OP_SRES)
      else $error("result raised outside the result step");

   a_csr_clears_table: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == kmp_pkg::CSR_PAT_LO || csr_index == kmp_pkg::CSR_PAT_HI ||
                 csr_index == kmp_pkg::CSR_PAT_LEN) |=> !flags.tbl_ready)
      else $error("failure table still marked ready after a pattern write");

endmodule

`default_nettype wire
